// ----- src/rcls_pkg.sv -----
// Shared types and constants of the list scheduler core.
// Self-contained; imported by the scheduler top level.
package rcls_pkg;

  // Widths fixed by the request and result fields
  localparam int IDX_W      = 6;
  localparam int OP_W       = 2;
  localparam int CNT_W      = 4;
  localparam int STEP_OUT_W = 6;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADDER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_COUNT  = 1'b1;

  // Steps until an operation's result is available
  localparam int ADD_LAT = 1;
  localparam int MUL_LAT = 3;

  // Node operation; also the kind recorded in the node table
  typedef enum logic [OP_W-1:0] {
    OP_OTHER = 2'd0,
    OP_ADD   = 2'd1,
    OP_MUL   = 2'd2
  } opcode_e;

  // One word of the per-step usage memory
  typedef struct packed {
    logic [CNT_W-1:0] adders;
    logic [CNT_W-1:0] mults;
  } usage_t;

endpackage

// ----- src/rcls_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rcls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/resource_constrained_list_scheduler_core.sv -----
// Resource-constrained list scheduler: node table and per-step usage in two RAMs.
// Depends on rcls_pkg and rcls_ram.
// A request passes RD1, RD2 and CALC; unless it overflows there, an add or multiply
// searches forward over control steps (one per cycle, through the single read port
// of the usage RAM; a multiply reads at least three); a multiply books in MB1, MB2.
// One request is worked on at a time; the next is taken once the core is back in
// idle after the result moves to the output register. After reset a clearing pass
// over max(MAX_NODES, MAX_STEPS) addresses zeroes both RAMs; no request is taken
// until it ends; configuration writes are always taken. Unit counts reset to one.
module resource_constrained_list_scheduler_core #(
  parameter int MAX_STEPS = 64,
  parameter int MAX_NODES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rcls_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rcls_pkg::CNT_W-1:0]         cfg_data_i,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rcls_pkg::IDX_W-1:0]         node_index_i,
  input  logic [rcls_pkg::OP_W-1:0]          opcode_i,
  input  logic [rcls_pkg::IDX_W-1:0]         first_pred_index_i,
  input  logic                               first_pred_present_i,
  input  logic [rcls_pkg::IDX_W-1:0]         second_pred_index_i,
  input  logic                               second_pred_present_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rcls_pkg::IDX_W-1:0]         scheduled_node_o,
  output logic [rcls_pkg::STEP_OUT_W-1:0]    start_step_o,
  output logic                               overflow_o
);

  import rcls_pkg::*;

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int STEP_W    = $clog2(MAX_STEPS);
  // Extended step width: holds a finish step up to MAX_STEPS+2 and the search margin
  localparam int EW        = STEP_W + 1;
  localparam int NRAM_W    = OP_W + STEP_W;
  localparam int CLR_DEPTH = (MAX_NODES > MAX_STEPS) ? MAX_NODES : MAX_STEPS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  // Reciprocal for the node index modulo: exact for 6-bit indexes and any depth >= 4
  localparam int RECIP_SH  = 12;
  localparam int RECIP     = ((1 << RECIP_SH) + MAX_NODES - 1) / MAX_NODES;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_STEPS - 1);
  localparam logic [EW-1:0]     STEPS_E   = EW'(MAX_STEPS);
  localparam logic [CLR_W-1:0]  CLR_LAST  = CLR_W'(CLR_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_CALC,
    ST_SCAN,
    ST_MB1,
    ST_MB2,
    ST_DONE
  } state_e;

  // Fold a node index into the table depth: q = floor(v / MAX_NODES), rem = v - q*N
  function automatic logic [NODE_W-1:0] node_addr(input logic [IDX_W-1:0] v);
    logic [17:0] prod;
    logic [11:0] quo_n;
    logic [11:0] rem;
    prod  = 18'(v) * 18'(RECIP);
    quo_n = 12'(prod[17:RECIP_SH]) * 12'(MAX_NODES);
    rem   = 12'(v) - quo_n;
    return rem[NODE_W-1:0];
  endfunction

  // Finish step of a predecessor read from the node table; zero if it does not count
  function automatic logic [EW-1:0] pred_finish(input logic [NRAM_W-1:0] w,
                                                input logic present);
    logic [EW-1:0] st;
    logic [EW-1:0] fin;
    st  = EW'(w[STEP_W-1:0]);
    fin = '0;
    if (present) begin
      unique case (w[NRAM_W-1:STEP_W])
        OP_ADD:  fin = st + EW'(ADD_LAT);
        OP_MUL:  fin = st + EW'(MUL_LAT);
        default: fin = '0;
      endcase
    end
    return fin;
  endfunction

  state_e                 state_q;
  logic [CLR_W-1:0]       clr_q;
  logic [CNT_W-1:0]       adder_count_q;
  logic [CNT_W-1:0]       mult_count_q;
  logic [NODE_W-1:0]      node_q;
  logic [IDX_W-1:0]       echo_q;
  opcode_e                op_q;
  logic [NODE_W-1:0]      p1_q;
  logic [NODE_W-1:0]      p2_q;
  logic                   p1_pres_q;
  logic                   p2_pres_q;
  logic [EW-1:0]          t1_q;
  logic [EW-1:0]          s_q;
  logic [STEP_W-1:0]      issue_q;
  logic [STEP_W-1:0]      chk_q;
  logic                   chk_vld_q;
  logic [1:0]             run_q;
  usage_t                 win0_q;
  usage_t                 win1_q;
  logic                   res_ovf_q;
  logic                   out_valid_q;
  logic [IDX_W-1:0]       out_node_q;
  logic [STEP_OUT_W-1:0]  out_step_q;
  logic                   out_ovf_q;

  // RAM ports
  logic                   node_we;
  logic [NODE_W-1:0]      node_waddr;
  logic [NRAM_W-1:0]      node_wdata;
  logic [NODE_W-1:0]      node_raddr;
  logic [NRAM_W-1:0]      node_rdata;
  logic                   usage_we;
  logic [STEP_W-1:0]      usage_waddr;
  usage_t                 usage_wdata;
  usage_t                 usage_rdata;

  // Datapath decisions
  logic [EW-1:0]          t2;
  logic [EW-1:0]          s0;
  logic                   calc_ovf;
  logic                   step_free;
  logic                   found;
  logic                   scan_end;
  logic [STEP_W-1:0]      found_step;
  logic [STEP_W-1:0]      s_low;

  assign s_low = s_q[STEP_W-1:0];

  // Earliest step from both predecessors; second one's entry arrives in CALC
  always_comb begin
    t2 = pred_finish(node_rdata, p2_pres_q);
    if (t1_q == '0 && t2 == '0) begin
      s0 = EW'(1);
    end else begin
      s0 = (t1_q > t2) ? t1_q : t2;
    end
    if (op_q == OP_MUL) begin
      calc_ovf = (s0 + EW'(2)) >= STEPS_E;
    end else begin
      calc_ovf = s0 >= STEPS_E;
    end
  end

  // Forward search: one usage word checked per cycle; a multiply needs a run of three
  always_comb begin
    if (op_q == OP_ADD) begin
      step_free  = usage_rdata.adders < adder_count_q;
      found      = chk_vld_q && step_free;
      found_step = chk_q;
    end else begin
      step_free  = usage_rdata.mults < mult_count_q;
      found      = chk_vld_q && step_free && (run_q == 2'd2);
      found_step = chk_q - STEP_W'(2);
    end
    scan_end = chk_vld_q && (chk_q == LAST_STEP);
  end

  // RAM control: clearing pass, node record, usage booking write-back
  always_comb begin
    node_raddr  = (state_q == ST_RD1) ? p1_q : p2_q;
    node_we     = 1'b0;
    node_waddr  = node_q;
    node_wdata  = {op_q, found_step};
    usage_we    = 1'b0;
    usage_waddr = chk_q;
    usage_wdata = usage_rdata;
    unique case (state_q)
      ST_CLR: begin
        node_we     = 32'(clr_q) < MAX_NODES;
        node_waddr  = clr_q[NODE_W-1:0];
        node_wdata  = '0;
        usage_we    = 32'(clr_q) < MAX_STEPS;
        usage_waddr = clr_q[STEP_W-1:0];
        usage_wdata = '0;
      end
      ST_CALC: begin
        // other operations book nothing; record them at the earliest step
        node_we    = (op_q == OP_OTHER) && !calc_ovf;
        node_wdata = {op_q, s0[STEP_W-1:0]};
      end
      ST_SCAN: begin
        node_we  = found;
        usage_we = found;
        if (op_q == OP_ADD) begin
          usage_wdata.adders = usage_rdata.adders + CNT_W'(1);
        end else begin
          usage_wdata.mults = usage_rdata.mults + CNT_W'(1);
        end
      end
      ST_MB1: begin
        usage_we          = 1'b1;
        usage_waddr       = s_low + STEP_W'(1);
        usage_wdata       = win0_q;
        usage_wdata.mults = win0_q.mults + CNT_W'(1);
      end
      ST_MB2: begin
        usage_we          = 1'b1;
        usage_waddr       = s_low;
        usage_wdata       = win1_q;
        usage_wdata.mults = win1_q.mults + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready_o      = 1'b1;
  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign scheduled_node_o = out_node_q;
  assign start_step_o     = out_step_q;
  assign overflow_o       = out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLR;
      clr_q         <= '0;
      adder_count_q <= CNT_W'(1);
      mult_count_q  <= CNT_W'(1);
      node_q        <= '0;
      echo_q        <= '0;
      op_q          <= OP_OTHER;
      p1_q          <= '0;
      p2_q          <= '0;
      p1_pres_q     <= 1'b0;
      p2_pres_q     <= 1'b0;
      t1_q          <= '0;
      s_q           <= '0;
      issue_q       <= '0;
      chk_q         <= '0;
      chk_vld_q     <= 1'b0;
      run_q         <= '0;
      win0_q        <= '0;
      win1_q        <= '0;
      res_ovf_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_node_q    <= '0;
      out_step_q    <= '0;
      out_ovf_q     <= 1'b0;
    end else begin
      // configuration is taken in any state
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ADDER_COUNT: adder_count_q <= cfg_data_i;
          CFG_MULT_COUNT:  mult_count_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // drop the result once taken; in DONE the refill below owns the flag
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + CLR_W'(1);
          if (clr_q == CLR_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            node_q    <= node_addr(node_index_i);
            echo_q    <= node_index_i;
            p1_q      <= node_addr(first_pred_index_i);
            p2_q      <= node_addr(second_pred_index_i);
            p1_pres_q <= first_pred_present_i;
            p2_pres_q <= second_pred_present_i;
            unique case (opcode_i)
              OP_ADD:  op_q <= OP_ADD;
              OP_MUL:  op_q <= OP_MUL;
              default: op_q <= OP_OTHER;
            endcase
            state_q <= ST_RD1;
          end
        end
        ST_RD1: begin
          state_q <= ST_RD2;
        end
        ST_RD2: begin
          t1_q    <= pred_finish(node_rdata, p1_pres_q);
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          s_q       <= s0;
          issue_q   <= s0[STEP_W-1:0];
          chk_vld_q <= 1'b0;
          run_q     <= '0;
          res_ovf_q <= calc_ovf;
          if (calc_ovf || op_q == OP_OTHER) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // advance the read address, holding at the last step
          if (issue_q != LAST_STEP) begin
            issue_q <= issue_q + STEP_W'(1);
          end
          chk_q     <= issue_q;
          chk_vld_q <= 1'b1;
          if (found) begin
            s_q       <= EW'(found_step);
            res_ovf_q <= 1'b0;
            state_q   <= (op_q == OP_ADD) ? ST_DONE : ST_MB1;
          end else if (chk_vld_q) begin
            // hold the two previous words of the run for the multiply write-back
            win0_q <= usage_rdata;
            win1_q <= win0_q;
            run_q  <= step_free ? run_q + 2'd1 : 2'd0;
            if (scan_end) begin
              res_ovf_q <= 1'b1;
              state_q   <= ST_DONE;
            end
          end
        end
        ST_MB1: begin
          state_q <= ST_MB2;
        end
        ST_MB2: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_node_q  <= echo_q;
            out_step_q  <= res_ovf_q ? '0 : STEP_OUT_W'(s_q);
            out_ovf_q   <= res_ovf_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  rcls_ram #(
    .WIDTH (NRAM_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  rcls_ram #(
    .WIDTH ($bits(usage_t)),
    .DEPTH (MAX_STEPS)
  ) u_usage_ram (
    .clk_i   (clk_i),
    .we_i    (usage_we),
    .waddr_i (usage_waddr),
    .wdata_i (usage_wdata),
    .raddr_i (issue_q),
    .rdata_o (usage_rdata)
  );

  // An adder booking never takes a step past the configured count
  a_add_within_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && usage_we && op_q == OP_ADD) |->
      (usage_wdata.adders <= adder_count_q))
    else $error("adder booked beyond configured count");

  // An overflowing request leaves the node table untouched
  a_ovf_no_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_ovf_q) |-> !$past(node_we))
    else $error("node table written for an overflowing request");

  // A multiply booking always lies wholly within the step range
  a_mul_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MB1) |-> ((s_q + EW'(2)) < STEPS_E))
    else $error("multiply booked past the last step");

  // A new result only ever comes from the completion state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside completion");

endmodule

// ----- sim/resource_constrained_list_scheduler_core_tb.sv -----
// Self-checking testbench for the resource-constrained list scheduler core.
// Depends on rcls_pkg and the core; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module resource_constrained_list_scheduler_core_tb;
  import rcls_pkg::*;

  localparam int NODE_COUNT  = 64;
  localparam int STEP_COUNT  = 64;
  // Fourth opcode value: the core treats it as a resource-free node
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  // Cycles with no handshake on any channel before the run is called dead
  localparam int QUIET_LIMIT = 3000;
  // Long receiver hold-off used to back the core up into its request port
  localparam int HOLD_CYCLES = 400;
  // The slowest request is a multiply that searches every step
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [IDX_W-1:0] node;
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] first_pred;
    logic             first_present;
    logic [IDX_W-1:0] second_pred;
    logic             second_present;
  } sched_request_t;

  typedef struct packed {
    logic [IDX_W-1:0]      node;
    logic [STEP_OUT_W-1:0] step;
    logic                  ovf;
  } sched_result_t;

  // Tracks node placements and per-step unit bookings, and queues the result
  // each accepted request must produce.
  class schedule_scoreboard;
    int            adder_units;
    int            mult_units;
    opcode_e       kind_of [NODE_COUNT];
    int            start_of [NODE_COUNT];
    int            adds_used [STEP_COUNT];
    int            muls_used [STEP_COUNT];
    sched_result_t awaited_q [$];
    int            errors;

    function new();
      adder_units = 1;
      mult_units  = 1;
      errors      = 0;
      foreach (kind_of[i]) begin
        kind_of[i]  = OP_OTHER;
        start_of[i] = 0;
      end
      foreach (adds_used[i]) begin
        adds_used[i] = 0;
        muls_used[i] = 0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_register(logic [CFG_IDX_W-1:0] idx, int value);
      if (idx == CFG_ADDER_COUNT) begin
        adder_units = value;
      end else begin
        mult_units = value;
      end
    endfunction

    // Step at which a predecessor's result is ready; zero if it does not count
    function int finish_of(logic [IDX_W-1:0] idx, logic present);
      if (!present) return 0;
      case (kind_of[idx])
        OP_ADD:  return start_of[idx] + ADD_LAT;
        OP_MUL:  return start_of[idx] + MUL_LAT;
        default: return 0;
      endcase
    endfunction

    function bit mult_window_free(int s);
      return muls_used[s] < mult_units && muls_used[s + 1] < mult_units &&
             muls_used[s + 2] < mult_units;
    endfunction

    function void note_request(sched_request_t r);
      opcode_e       kind;
      int            f1;
      int            f2;
      int            s;
      bit            ovf;
      sched_result_t res;
      kind = (r.opcode == OP_SPARE) ? OP_OTHER : opcode_e'(r.opcode);
      f1   = finish_of(r.first_pred, r.first_present);
      f2   = finish_of(r.second_pred, r.second_present);
      s    = (f1 == 0 && f2 == 0) ? 1 : ((f1 > f2) ? f1 : f2);
      ovf  = 1'b0;
      case (kind)
        OP_ADD: begin
          while (s < STEP_COUNT && adds_used[s] >= adder_units) s++;
          if (s >= STEP_COUNT) ovf = 1'b1;
          else adds_used[s]++;
        end
        OP_MUL: begin
          while (s + 2 < STEP_COUNT && !mult_window_free(s)) s++;
          if (s + 2 >= STEP_COUNT) begin
            ovf = 1'b1;
          end else begin
            muls_used[s]++;
            muls_used[s + 1]++;
            muls_used[s + 2]++;
          end
        end
        default: ovf = (s >= STEP_COUNT);
      endcase
      if (!ovf) begin
        kind_of[r.node]  = kind;
        start_of[r.node] = s;
      end
      res.node = r.node;
      res.step = ovf ? '0 : s[STEP_OUT_W-1:0];
      res.ovf  = ovf;
      awaited_q.push_back(res);
    endfunction

    task check_result(logic [IDX_W-1:0] node, logic [STEP_OUT_W-1:0] step, logic ovf);
      sched_result_t want;
      if (awaited_q.size() == 0) begin
        report($sformatf("result for node %0d with nothing awaited", node));
        return;
      end
      want = awaited_q.pop_front();
      if (node !== want.node)
        report($sformatf("scheduled_node got %0d want %0d", node, want.node));
      if (step !== want.step)
        report($sformatf("start_step of node %0d got %0d want %0d", want.node, step,
                         want.step));
      if (ovf !== want.ovf)
        report($sformatf("overflow of node %0d got %0d want %0d", want.node, ovf,
                         want.ovf));
    endtask

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic                  clk_i                 = 1'b0;
  logic                  rst_ni                = 1'b0;
  logic                  cfg_valid_i           = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i           = CFG_ADDER_COUNT;
  logic [CNT_W-1:0]      cfg_data_i            = '0;
  logic                  in_valid_i            = 1'b0;
  logic                  in_ready_o;
  logic [IDX_W-1:0]      node_index_i          = '0;
  logic [OP_W-1:0]       opcode_i              = OP_OTHER;
  logic [IDX_W-1:0]      first_pred_index_i    = '0;
  logic                  first_pred_present_i  = 1'b0;
  logic [IDX_W-1:0]      second_pred_index_i   = '0;
  logic                  second_pred_present_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i           = 1'b0;
  logic [IDX_W-1:0]      scheduled_node_o;
  logic [STEP_OUT_W-1:0] start_step_o;
  logic                  overflow_o;

  // Idling knobs, in percent; holding forces the result side to stall
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic holding      = 1'b0;
  int quiet_cycles   = 0;

  schedule_scoreboard sched;

  resource_constrained_list_scheduler_core #(
    .MAX_STEPS(STEP_COUNT),
    .MAX_NODES(NODE_COUNT)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .node_index_i         (node_index_i),
    .opcode_i             (opcode_i),
    .first_pred_index_i   (first_pred_index_i),
    .first_pred_present_i (first_pred_present_i),
    .second_pred_index_i  (second_pred_index_i),
    .second_pred_present_i(second_pred_present_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .scheduled_node_o     (scheduled_node_o),
    .start_step_o         (start_step_o),
    .overflow_o           (overflow_o)
  );

  always #2 clk_i = ~clk_i;

  // Result side: stall at random, or hold off completely while holding is set
  always @(posedge clk_i) begin
    out_ready_i <= !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result taken at this edge against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sched.check_result(scheduled_node_o, start_step_o, overflow_o);
  end

  // Give up when no channel has moved for far longer than any correct stall
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("resource_constrained_list_scheduler_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic sched_request_t make_request(
    logic [IDX_W-1:0] node, logic [OP_W-1:0] opcode,
    logic [IDX_W-1:0] p1, logic p1_present, logic [IDX_W-1:0] p2, logic p2_present
  );
    sched_request_t r;
    r.node           = node;
    r.opcode         = opcode;
    r.first_pred     = p1;
    r.first_present  = p1_present;
    r.second_pred    = p2;
    r.second_present = p2_present;
    return r;
  endfunction

  // Offer one request, idling first at random; leave valid high on acceptance
  // so that the next call either lowers it or replaces the payload.
  task automatic send_request(sched_request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    node_index_i          <= r.node;
    opcode_i              <= r.opcode;
    first_pred_index_i    <= r.first_pred;
    first_pred_present_i  <= r.first_present;
    second_pred_index_i   <= r.second_pred;
    second_pred_present_i <= r.second_present;
    do @(posedge clk_i); while (!in_ready_o);
    sched.note_request(r);
  endtask

  // Write both unit counts; only called while nothing is in flight
  task automatic set_unit_counts(logic [CNT_W-1:0] adders, logic [CNT_W-1:0] mults);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_ADDER_COUNT;
    cfg_data_i  <= adders;
    do @(posedge clk_i); while (!cfg_ready_o);
    sched.write_register(CFG_ADDER_COUNT, int'(adders));
    cfg_index_i <= CFG_MULT_COUNT;
    cfg_data_i  <= mults;
    do @(posedge clk_i); while (!cfg_ready_o);
    sched.write_register(CFG_MULT_COUNT, int'(mults));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sched.pending() != 0) @(posedge clk_i);
  endtask

  task automatic hold_results(int cycles);
    @(negedge clk_i) holding = 1'b1;
    repeat (cycles) @(posedge clk_i);
    @(negedge clk_i) holding = 1'b0;
  endtask

  // Send small dataflow graphs: most nodes name earlier nodes of the same graph
  // as predecessors, so chains build up; one in ten is pure noise.
  task automatic send_graphs(int count);
    sched_request_t   r;
    logic [IDX_W-1:0] members [$];
    int               left;
    int               size;
    int               pick;
    left = count;
    while (left > 0) begin
      members.delete();
      size = $urandom_range(12, 3);
      for (int k = 0; k < size && left > 0; k++) begin
        r.node           = IDX_W'($urandom_range(NODE_COUNT - 1));
        r.opcode         = OP_W'($urandom_range(3));
        r.first_pred     = IDX_W'($urandom_range(NODE_COUNT - 1));
        r.first_present  = 1'($urandom_range(1));
        r.second_pred    = IDX_W'($urandom_range(NODE_COUNT - 1));
        r.second_present = 1'($urandom_range(1));
        if ($urandom_range(9) != 0) begin
          pick     = $urandom_range(9);
          r.opcode = (pick < 2) ? OP_OTHER : (pick < 6) ? OP_ADD : OP_MUL;
          if (members.size() != 0) begin
            r.first_present  = ($urandom_range(9) < 8);
            r.first_pred     = members[$urandom_range(members.size() - 1)];
            r.second_present = 1'($urandom_range(1));
            r.second_pred    = members[$urandom_range(members.size() - 1)];
          end else begin
            r.first_present  = 1'b0;
            r.second_present = 1'b0;
          end
        end
        send_request(r);
        members.push_back(r.node);
        left--;
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // One phase: drain, retune the unit counts, set the idling mix and send.
  task automatic run_phase(logic [CNT_W-1:0] adders, logic [CNT_W-1:0] mults,
                           int send_pct, int stall_pct, int count, bit squeeze);
    wait_drained();
    set_unit_counts(adders, mults);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    fork
      begin
        if (squeeze) hold_results(HOLD_CYCLES);
      end
      send_graphs(count);
    join
  endtask

  initial begin
    sched = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset unit counts of one adder and one multiplier.
    // Predecessors that are resource-free or never scheduled count for nothing.
    send_request(make_request(6'd0,  OP_OTHER, 6'd0,  1'b0, 6'd63, 1'b0));
    send_request(make_request(6'd63, OP_ADD,   6'd0,  1'b1, 6'd63, 1'b1));
    send_request(make_request(6'd1,  OP_ADD,   6'd0,  1'b0, 6'd0,  1'b0));
    send_request(make_request(6'd2,  OP_MUL,   6'd63, 1'b1, 6'd0,  1'b0));
    send_request(make_request(6'd3,  OP_MUL,   6'd2,  1'b1, 6'd1,  1'b1));
    // Fourth opcode behaves as a resource-free node
    send_request(make_request(6'd4,  OP_SPARE, 6'd3,  1'b1, 6'd63, 1'b0));
    send_request(make_request(6'd5,  OP_ADD,   6'd2,  1'b0, 6'd4,  1'b1));
    // Reschedule nodes, some of them naming themselves as predecessor
    send_request(make_request(6'd2,  OP_MUL,   6'd0,  1'b0, 6'd0,  1'b0));
    send_request(make_request(6'd6,  OP_ADD,   6'd2,  1'b1, 6'd3,  1'b1));
    send_request(make_request(6'd63, OP_MUL,   6'd63, 1'b1, 6'd63, 1'b1));
    send_request(make_request(6'd7,  OP_OTHER, 6'd63, 1'b1, 6'd5,  1'b1));
    send_request(make_request(6'd8,  OP_MUL,   6'd7,  1'b1, 6'd7,  1'b0));
    send_request(make_request(6'd9,  OP_ADD,   6'd8,  1'b1, 6'd3,  1'b1));
    send_request(make_request(6'd42, OP_SPARE, 6'd21, 1'b1, 6'd42, 1'b1));
    send_request(make_request(6'd21, OP_ADD,   6'd42, 1'b1, 6'd21, 1'b1));
    send_request(make_request(6'd63, OP_MUL,   6'd0,  1'b1, 6'd63, 1'b1));
    in_valid_i <= 1'b0;

    // No units at all: every add and multiply overflows and leaves no trace
    wait_drained();
    set_unit_counts(4'd0, 4'd0);
    send_request(make_request(6'd10, OP_ADD,   6'd0,  1'b0, 6'd0,  1'b0));
    send_request(make_request(6'd11, OP_MUL,   6'd63, 1'b1, 6'd9,  1'b1));
    send_request(make_request(6'd12, OP_OTHER, 6'd63, 1'b1, 6'd9,  1'b1));
    send_request(make_request(6'd13, OP_SPARE, 6'd12, 1'b1, 6'd11, 1'b1));
    in_valid_i <= 1'b0;

    // Random graphs under a spread of unit counts and idling mixes
    run_phase(4'd2,  4'd2,  0,  0,  240, 1'b0);
    run_phase(4'd3,  4'd1,  65, 0,  240, 1'b0);
    run_phase(4'd1,  4'd4,  0,  65, 240, 1'b0);
    run_phase(4'd0,  4'd15, 24, 24, 100, 1'b0);
    run_phase(4'd15, 4'd0,  0,  0,  100, 1'b0);
    run_phase(4'd6,  4'd6,  24, 24, 240, 1'b0);
    run_phase(4'd10, 4'd8,  0,  0,  240, 1'b1);
    run_phase(4'd15, 4'd15, 65, 0,  250, 1'b0);
    run_phase(4'd15, 4'd15, 0,  65, 280, 1'b0);

    // Drain, then linger so that any stray result still shows up
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sched.pending() != 0)
      sched.report($sformatf("%0d results never arrived", sched.pending()));
    if (sched.errors == 0) begin
      $display("resource_constrained_list_scheduler_core regression: pass");
    end else begin
      $display("resource_constrained_list_scheduler_core regression: fail");
    end
    $finish;
  end

endmodule
